>>> hdl/pse_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// pse_pkg
// Shared types and constants for the printable string extractor.
// ----------------------------------------------------------------------------
package pse_pkg;

  typedef struct packed {
    logic [7:0] cur_byte;
    logic [7:0] ahead_one;
    logic [7:0] ahead_two;
    logic [7:0] ahead_three;
    logic       last_in_range;
  } pse_in_t;

  typedef struct packed {
    logic [23:0] str_offset;
    logic [63:0] str_rva;
    logic [6:0]  str_size;
    logic [23:0] str_ordinal;
    logic [7:0]  text_byte;
    logic        last_char;
  } pse_out_t;

  typedef enum logic [1:0] {
    ST_SCAN,
    ST_PREP,
    ST_SHOW
  } pse_state_t;

  // controller to datapath
  typedef struct packed {
    logic accept;
    logic prep;
    logic out_xfer;
  } pse_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic emit_req;
    logic last_char;
  } pse_status_t;

  localparam int          CFG_AW          = 5;
  localparam logic [1:0]  CFG_MIN_LENGTH  = 2'd0;
  localparam logic [1:0]  CFG_RANGE_START = 2'd1;
  localparam logic [1:0]  CFG_SECTION_RVA = 2'd2;

  localparam logic [5:0]  MIN_LENGTH_RST  = 6'd4;
  localparam logic [23:0] POS_MASK        = 24'hffffff;

  localparam logic [7:0]  PRINT_LO        = 8'h20;
  localparam logic [7:0]  PRINT_HI        = 8'h7e;

  function automatic logic is_print(input logic [7:0] b);
    return (b >= PRINT_LO) && (b <= PRINT_HI);
  endfunction

endpackage
`default_nettype wire

>>> hdl/pse_ram.sv
`default_nettype none
// ----------------------------------------------------------------------------
// pse_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module pse_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 63
) (
  input  wire logic                     clk,
  input  wire logic                     wr_en,
  input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
  input  wire logic [WIDTH-1:0]         wr_data,
  input  wire logic                     rd_en,
  input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic      [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule
`default_nettype wire

>>> hdl/pse_cfg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// pse_cfg
// Configuration registers behind the APB-style port.
// ----------------------------------------------------------------------------
module pse_cfg (
  input  wire logic                       clk,
  input  wire logic                       rst_n,
  input  wire logic                       psel,
  input  wire logic                       penable,
  input  wire logic                       pwrite,
  input  wire logic [pse_pkg::CFG_AW-1:0] paddr,
  input  wire logic [63:0]                pwdata,
  output logic      [63:0]                prdata,
  output logic                            pready,
  output logic      [5:0]                 min_length,
  output logic      [23:0]                range_start,
  output logic      [63:0]                section_rva
);

  logic [5:0]  min_length_r;
  logic [23:0] range_start_r;
  logic [63:0] section_rva_r;
  logic        wr_xfer;
  logic [1:0]  reg_idx;

  assign pready  = 1'b1;
  assign wr_xfer = psel && penable && pwrite;
  assign reg_idx = paddr[4:3];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      min_length_r  <= pse_pkg::MIN_LENGTH_RST;
      range_start_r <= '0;
      section_rva_r <= '0;
    end else if (wr_xfer) begin
      unique case (reg_idx)
        pse_pkg::CFG_MIN_LENGTH:  min_length_r  <= pwdata[5:0];
        pse_pkg::CFG_RANGE_START: range_start_r <= pwdata[23:0];
        pse_pkg::CFG_SECTION_RVA: section_rva_r <= pwdata;
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx)
      pse_pkg::CFG_MIN_LENGTH:  prdata = {58'd0, min_length_r};
      pse_pkg::CFG_RANGE_START: prdata = {40'd0, range_start_r};
      pse_pkg::CFG_SECTION_RVA: prdata = section_rva_r;
      default:                  prdata = '0;
    endcase
  end

  assign min_length  = min_length_r;
  assign range_start = range_start_r;
  assign section_rva = section_rva_r;

endmodule
`default_nettype wire

>>> hdl/pse_ctrl.sv
`default_nettype none
// ----------------------------------------------------------------------------
// pse_ctrl
// Sequencer: scans items, then serializes a found string one char a cycle while out_stall is low.
// ----------------------------------------------------------------------------
module pse_ctrl (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 in_valid,
  output logic                      in_stall,
  output logic                      out_valid,
  input  wire logic                 out_stall,
  input  wire pse_pkg::pse_status_t status,
  output pse_pkg::pse_cmd_t         cmd
);

  pse_pkg::pse_state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= pse_pkg::ST_SCAN;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      pse_pkg::ST_SCAN: begin
        if (in_valid && status.emit_req) state_nxt = pse_pkg::ST_PREP;
      end
      pse_pkg::ST_PREP: begin
        state_nxt = pse_pkg::ST_SHOW;
      end
      pse_pkg::ST_SHOW: begin
        if (!out_stall && status.last_char) state_nxt = pse_pkg::ST_SCAN;
      end
      default: state_nxt = pse_pkg::ST_SCAN;
    endcase
  end

  always_comb begin
    in_stall     = 1'b1;
    out_valid    = 1'b0;
    cmd.accept   = 1'b0;
    cmd.prep     = 1'b0;
    cmd.out_xfer = 1'b0;
    unique case (state_r)
      pse_pkg::ST_SCAN: begin
        in_stall   = 1'b0;
        cmd.accept = in_valid;
      end
      pse_pkg::ST_PREP: begin
        cmd.prep = 1'b1;
      end
      pse_pkg::ST_SHOW: begin
        out_valid    = 1'b1;
        cmd.out_xfer = !out_stall;
      end
      default: ;
    endcase
  end

endmodule
`default_nettype wire

>>> hdl/pse_datapath.sv
`default_nettype none
// ----------------------------------------------------------------------------
// pse_datapath
// Scan position, run buffer, string counter and the string descriptor.
// ----------------------------------------------------------------------------
module pse_datapath #(
  parameter int MAX_LEN = 64
) (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire pse_pkg::pse_cmd_t    cmd,
  output pse_pkg::pse_status_t      status,
  input  wire pse_pkg::pse_in_t     in_data,
  output pse_pkg::pse_out_t         out_data,
  input  wire logic [5:0]           min_length,
  input  wire logic [23:0]          range_start,
  input  wire logic [63:0]          section_rva
);

  localparam int LW  = $clog2(MAX_LEN);
  localparam int AW  = $clog2(MAX_LEN - 1);
  localparam int CW  = (LW > 6) ? LW : 6;
  localparam int SZW = (LW + 1 > 7) ? LW + 1 : 7;
  localparam logic [LW-1:0] RUN_CAP = LW'(MAX_LEN - 1);

  logic [23:0]   pos_r, pos_nxt;
  logic [LW-1:0] len_r, len_nxt;
  logic [23:0]   cnt_r, cnt_nxt;
  logic          skip_r, skip_nxt;
  logic [LW-1:0] k_r;

  logic [LW-1:0] em_len_r;
  logic [25:0]   em_diff_r;
  logic [23:0]   em_ord_r;
  logic [23:0]   off_r;
  logic [63:0]   rva_r;

  logic          take_byte;
  logic          closing;
  logic [LW-1:0] len_after;
  logic          close_ok;
  logic          flush_ok;
  logic          emit_req;
  logic [24:0]   rel_end;
  logic [LW-1:0] emit_len;
  logic          ram_rd_en;
  logic [AW-1:0] ram_rd_addr;
  logic [7:0]    ram_rd_data;
  logic [SZW-1:0] size_w;

  function automatic logic reportable(input logic [LW-1:0] len, input logic [5:0] min_len);
    return (len != '0) && (CW'(len) >= CW'(min_len));
  endfunction

  always_comb begin
    take_byte = !skip_r && pse_pkg::is_print(in_data.cur_byte) && (len_r < RUN_CAP);
    closing   = !skip_r && !take_byte;
    if (take_byte) begin
      len_after = len_r + LW'(1);
    end else if (skip_r) begin
      len_after = len_r;
    end else begin
      len_after = '0;
    end
    close_ok = closing && reportable(len_r, min_length);
    // a pending run is flushed at the range end when nothing closed here
    flush_ok = in_data.last_in_range && !close_ok && reportable(len_after, min_length);
    emit_req = close_ok || flush_ok;
    rel_end  = close_ok ? {1'b0, pos_r} : ({1'b0, pos_r} + 25'd1);
    emit_len = close_ok ? len_r : len_after;
  end

  always_comb begin
    pos_nxt  = pos_r;
    len_nxt  = len_r;
    cnt_nxt  = cnt_r;
    skip_nxt = skip_r;
    if (cmd.accept) begin
      if (in_data.last_in_range) begin
        pos_nxt  = '0;
        len_nxt  = '0;
        cnt_nxt  = '0;
        skip_nxt = 1'b0;
      end else begin
        pos_nxt  = (pos_r + 24'd1) & pse_pkg::POS_MASK;
        len_nxt  = len_after;
        cnt_nxt  = emit_req ? cnt_r + 24'd1 : cnt_r;
        skip_nxt = take_byte && (in_data.ahead_one == 8'd0) &&
                   pse_pkg::is_print(in_data.ahead_two) && (in_data.ahead_three == 8'd0);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r  <= '0;
      len_r  <= '0;
      cnt_r  <= '0;
      skip_r <= 1'b0;
      k_r    <= '0;
    end else begin
      pos_r  <= pos_nxt;
      len_r  <= len_nxt;
      cnt_r  <= cnt_nxt;
      skip_r <= skip_nxt;
      if (cmd.prep) begin
        k_r <= '0;
      end else if (cmd.out_xfer) begin
        k_r <= k_r + LW'(1);
      end
    end
  end

  // string descriptor, latched at the reporting item and finished in the cycle after
  always_ff @(posedge clk) begin
    if (cmd.accept && emit_req) begin
      em_len_r  <= emit_len;
      em_diff_r <= {1'b0, rel_end} - 26'(emit_len);
      em_ord_r  <= cnt_r;
    end
    if (cmd.prep) begin
      off_r <= range_start + em_diff_r[23:0];
      rva_r <= {{38{em_diff_r[25]}}, em_diff_r} + section_rva;
    end
  end

  assign ram_rd_en   = cmd.prep || (cmd.out_xfer && !status.last_char);
  assign ram_rd_addr = cmd.prep ? '0 : AW'(k_r + LW'(1));

  pse_ram #(
    .WIDTH (8),
    .DEPTH (MAX_LEN - 1)
  ) u_run_buf (
    .clk     (clk),
    .wr_en   (cmd.accept && take_byte),
    .wr_addr (len_r[AW-1:0]),
    .wr_data (in_data.cur_byte),
    .rd_en   (ram_rd_en),
    .rd_addr (ram_rd_addr),
    .rd_data (ram_rd_data)
  );

  assign size_w = SZW'(em_len_r) + SZW'(1);

  assign status.emit_req  = emit_req;
  assign status.last_char = (k_r + LW'(1)) == em_len_r;

  assign out_data.str_offset  = off_r;
  assign out_data.str_rva     = rva_r;
  assign out_data.str_size    = size_w[6:0];
  assign out_data.str_ordinal = em_ord_r;
  assign out_data.text_byte   = ram_rd_data;
  assign out_data.last_char   = status.last_char;

endmodule
`default_nettype wire

>>> hdl/printable_string_extractor_top.sv
`default_nettype none
// ----------------------------------------------------------------------------
// printable_string_extractor_top
// Scans a byte range and reports runs of printable characters, one result
// per character of each reported string.
// ----------------------------------------------------------------------------
//   channel  | handshake          | payload
//   ---------+--------------------+-------------------------------
//   in       | in_valid/in_stall  | in_data   (pse_in_t)
//   out      | out_valid/out_stall| out_data  (pse_out_t)
//   cfg      | psel/penable/pready| paddr, pwdata, prdata (64 bit)
//
// one input transfer per cycle while scanning; an item that reports a string
// holds the input stalled while the descriptor is prepared and then while each
// character is read through the run buffer's read port. out_stall stretches
// each character cycle. reset clears control state only; the run buffer needs
// no clearing pass.
// ----------------------------------------------------------------------------
module printable_string_extractor_top #(
  parameter int MAX_LEN = 64
) (
  input  wire logic                       clk,
  input  wire logic                       rst_n,
  input  wire logic                       in_valid,
  output logic                            in_stall,
  input  wire pse_pkg::pse_in_t           in_data,
  output logic                            out_valid,
  input  wire logic                       out_stall,
  output pse_pkg::pse_out_t               out_data,
  input  wire logic                       psel,
  input  wire logic                       penable,
  input  wire logic                       pwrite,
  input  wire logic [pse_pkg::CFG_AW-1:0] paddr,
  input  wire logic [63:0]                pwdata,
  output logic      [63:0]                prdata,
  output logic                            pready
);

  logic [5:0]           min_length;
  logic [23:0]          range_start;
  logic [63:0]          section_rva;
  pse_pkg::pse_cmd_t    cmd;
  pse_pkg::pse_status_t status;

  pse_cfg u_cfg (
    .clk         (clk),
    .rst_n       (rst_n),
    .psel        (psel),
    .penable     (penable),
    .pwrite      (pwrite),
    .paddr       (paddr),
    .pwdata      (pwdata),
    .prdata      (prdata),
    .pready      (pready),
    .min_length  (min_length),
    .range_start (range_start),
    .section_rva (section_rva)
  );

  pse_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .status    (status),
    .cmd       (cmd)
  );

  pse_datapath #(
    .MAX_LEN (MAX_LEN)
  ) u_datapath (
    .clk         (clk),
    .rst_n       (rst_n),
    .cmd         (cmd),
    .status      (status),
    .in_data     (in_data),
    .out_data    (out_data),
    .min_length  (min_length),
    .range_start (range_start),
    .section_rva (section_rva)
  );

endmodule
`default_nettype wire
